### src/twrq_pkg.sv
// ----------------------------------------------------------------------------
// twrq_pkg
// Shared types and constants for the transmit window retransmit queue.
// ----------------------------------------------------------------------------
`default_nettype none

package twrq_pkg;

	localparam int unsigned WINDOW_SLOTS = 1024;
	localparam int unsigned SLOT_W       = $clog2(WINDOW_SLOTS);
	localparam int unsigned SEQ_W        = 32;
	localparam int unsigned LEN_W        = 16;
	localparam int unsigned CNT_W        = 8;
	localparam int unsigned BYTES_W      = 26;
	localparam int unsigned FILL_W       = 11;
	localparam int unsigned GS_W         = 3;
	localparam int unsigned CMD_W        = 3;
	localparam int unsigned STAT_W       = 3;

	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SNAK   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PNAK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_WIN_EMPTY = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_IN    = 3'd2;
	localparam logic [STAT_W-1:0] ST_DUP       = 3'd3;
	localparam logic [STAT_W-1:0] ST_Q_EMPTY   = 3'd4;

	localparam logic REG_GROUP_SHIFT = 1'b0;
	localparam logic REG_PARITY_SPAN = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_EXE  = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CNT_W-1:0] rem;
	} rem_rsp_t;

endpackage

`default_nettype wire

### src/twrq_ram.sv
// ----------------------------------------------------------------------------
// twrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module twrq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### src/twrq_rem.sv
// ----------------------------------------------------------------------------
// twrq_rem
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module twrq_rem (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire twrq_pkg::rem_req_t  req,
	output twrq_pkg::rem_rsp_t       rsp
);
	import twrq_pkg::*;

	localparam int unsigned STEP_W = $clog2(CNT_W);

	logic              busy_q, done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [CNT_W-1:0]  a_q, d_q, r_q;
	logic [CNT_W:0]    r_sh;
	logic [CNT_W:0]    r_sub;

	assign r_sh  = {r_q, a_q[CNT_W-1]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(CNT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.dividend;
			d_q <= req.divisor;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[CNT_W-2:0], 1'b0};
			if (r_sh >= {1'b0, d_q}) begin
				r_q <= r_sub[CNT_W-1:0];
			end else begin
				r_q <= r_sh[CNT_W-1:0];
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = r_q;

endmodule

`default_nettype wire

### src/transmit_window_retransmit_queue_top.sv
// ----------------------------------------------------------------------------
// transmit_window_retransmit_queue_top
// Transmit window ring with a linked retransmit request queue.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                 | content
//  s_*      | in  | s_tvalid / s_tready       | command item
//  m_*      | out | m_tvalid / m_tready       | result item
//  apb      | in  | psel, penable, pready     | group_shift, parity_span
//
//  An item passes through accept, slot memory read, update and result.
//  A head with a parity request and nonzero span adds a wait for the bit-serial
//  remainder unit. Reset sets the sequence counters to an empty window and
//  clears the queue pointers; slot memory is not cleared. One item is held at
//  a time; a stalled result holds s_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module transmit_window_retransmit_queue_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [47:0]  s_tdata,  // nak_sequence[31:0], packet_len[47:32]
	input  wire logic [2:0]   s_tuser,  // cmd[2:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [119:0] m_tdata   // accepted[0], status[3:1], seq_out[35:4],
	                                    // head_is_parity[36], parity_index[44:37],
	                                    // group_base[76:45], fill_count[87:77],
	                                    // byte_total[113:88]
);
	import twrq_pkg::*;

	state_t state_q, state_d;

	logic [CMD_W-1:0]   cmd_q;
	logic [SEQ_W-1:0]   nseq_q;
	logic [LEN_W-1:0]   plen_q;
	logic [GS_W-1:0]    gs_q;
	logic [CNT_W-1:0]   span_q;

	logic [SEQ_W-1:0]   lead_q, trail_q, lead_d, trail_d;
	logic [BYTES_W-1:0] held_q, held_d;
	logic [SLOT_W-1:0]  first_q, last_q, first_d, last_d;
	logic               nonempty_q, nonempty_d;

	logic               acc_q, acc_d, par_q, par_d;
	logic [STAT_W-1:0]  status_q, status_d;
	logic [SEQ_W-1:0]   seq_q, seq_d;
	logic [CNT_W-1:0]   pidx_q;
	logic               div_go;

	logic               wait_we, req_we, sent_we, len_we, prev_we, next_we;
	logic [SLOT_W-1:0]  wait_wa, req_wa, sent_wa, len_wa, prev_wa, next_wa;
	logic               wait_wd;
	logic [CNT_W-1:0]   req_wd, sent_wd;
	logic [SLOT_W-1:0]  prev_wd, next_wd;
	logic [SLOT_W-1:0]  rd_addr;
	logic               wait_rd;
	logic [CNT_W-1:0]   req_rd, sent_rd;
	logic [LEN_W-1:0]   len_rd;
	logic [SLOT_W-1:0]  prev_rd, next_rd;

	logic [SEQ_W-1:0]   gmask, target, fill, lead_inc, seq_fill;
	logic [CNT_W-1:0]   count8, sent_inc;
	logic               full, empty, in_win, is_pnak;
	logic [SLOT_W-1:0]  trail_slot, add_slot, head_off;

	logic               un_en;
	logic [SLOT_W-1:0]  un_s;

	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PARITY_SPAN) ? {24'd0, span_q} : {29'd0, gs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q   <= '0;
			span_q <= 8'd1;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_GROUP_SHIFT) begin
				gs_q <= pwdata[GS_W-1:0];
			end else begin
				span_q <= pwdata[CNT_W-1:0];
			end
		end
	end

	assign gmask      = {SEQ_W{1'b1}} << gs_q;
	assign is_pnak    = (cmd_q == CMD_PNAK);
	assign target     = is_pnak ? (nseq_q & gmask) : nseq_q;
	assign count8     = nseq_q[CNT_W-1:0] & ~gmask[CNT_W-1:0];
	assign fill       = lead_q + 1'b1 - trail_q;
	assign full       = (fill == SEQ_W'(WINDOW_SLOTS));
	assign empty      = (fill == '0);
	assign in_win     = ((target - trail_q) <= (lead_q - trail_q));
	assign lead_inc   = lead_q + 1'b1;
	assign trail_slot = trail_q[SLOT_W-1:0];
	assign add_slot   = lead_inc[SLOT_W-1:0];
	assign head_off   = first_q - trail_slot;
	assign seq_fill   = trail_q + {{(SEQ_W-SLOT_W){1'b0}}, head_off};
	assign sent_inc   = sent_rd + 1'b1;

	always_comb begin
		case (cmd_q)
			CMD_ADD:               rd_addr = trail_slot;
			CMD_SNAK, CMD_PNAK:    rd_addr = target[SLOT_W-1:0];
			CMD_PEEK, CMD_REMOVE:  rd_addr = first_q;
			default:               rd_addr = '0;
		endcase
	end

	always_comb begin
		lead_d = lead_q;   trail_d = trail_q;  held_d = held_q;
		first_d = first_q; last_d = last_q;    nonempty_d = nonempty_q;
		acc_d = 1'b0; par_d = 1'b0; status_d = ST_OK; seq_d = '0; div_go = 1'b0;
		wait_we = 1'b0; wait_wa = '0; wait_wd = 1'b0;
		req_we  = 1'b0; req_wa  = '0; req_wd  = '0;
		sent_we = 1'b0; sent_wa = '0; sent_wd = '0;
		len_we  = 1'b0; len_wa  = '0;
		prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
		next_we = 1'b0; next_wa = '0; next_wd = '0;
		un_en = 1'b0; un_s = '0;
		if (state_q == S_EXE) begin
			case (cmd_q)
				CMD_ADD: begin
					if (full) begin
						un_en   = nonempty_q && wait_rd;
						un_s    = trail_slot;
						trail_d = trail_q + 1'b1;
						held_d  = held_q - {{(BYTES_W-LEN_W){1'b0}}, len_rd};
					end
					held_d  = held_d + {{(BYTES_W-LEN_W){1'b0}}, plen_q};
					lead_d  = lead_inc;
					seq_d   = lead_inc;
					len_we  = 1'b1; len_wa  = add_slot;
					wait_we = 1'b1; wait_wa = add_slot; wait_wd = 1'b0;
					req_we  = 1'b1; req_wa  = add_slot; req_wd  = '0;
					sent_we = 1'b1; sent_wa = add_slot; sent_wd = '0;
				end
				CMD_SNAK, CMD_PNAK: begin
					if (empty) begin
						status_d = ST_WIN_EMPTY;
					end else if (!in_win) begin
						status_d = ST_NOT_IN;
					end else if (wait_rd) begin
						status_d = ST_DUP;
						if (is_pnak && (req_rd < count8)) begin
							req_we = 1'b1; req_wa = rd_addr; req_wd = count8;
						end
					end else begin
						acc_d = 1'b1;
						if (is_pnak) begin
							req_we = 1'b1; req_wa = rd_addr; req_wd = req_rd + 1'b1;
						end
						if (!nonempty_q) begin
							first_d    = rd_addr;
							nonempty_d = 1'b1;
						end else begin
							next_we = 1'b1; next_wa = last_q;  next_wd = rd_addr;
							prev_we = 1'b1; prev_wa = rd_addr; prev_wd = last_q;
						end
						last_d  = rd_addr;
						wait_we = 1'b1; wait_wa = rd_addr; wait_wd = 1'b1;
					end
				end
				CMD_PEEK, CMD_REMOVE: begin
					if (!nonempty_q) begin
						status_d = ST_Q_EMPTY;
					end else begin
						seq_d  = seq_fill;
						par_d  = (req_rd != '0);
						div_go = par_d && (span_q != '0);
						if (cmd_q == CMD_REMOVE) begin
							un_s = first_q;
							if (par_d) begin
								sent_we = 1'b1; sent_wa = first_q; sent_wd = sent_inc;
								un_en   = (sent_inc == req_rd);
							end else begin
								un_en = 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
			if (un_en) begin
				wait_we = 1'b1; wait_wa = un_s; wait_wd = 1'b0;
				if (un_s == first_q && un_s == last_q) begin
					nonempty_d = 1'b0;
				end else if (un_s == first_q) begin
					first_d = next_rd;
				end else if (un_s == last_q) begin
					last_d = prev_rd;
				end else begin
					next_we = 1'b1; next_wa = prev_rd; next_wd = next_rd;
					prev_we = 1'b1; prev_wa = next_rd; prev_wd = prev_rd;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (s_tvalid) state_d = S_RD;
			S_RD:    state_d = S_EXE;
			S_EXE:   state_d = div_go ? S_DIV : S_OUT;
			S_DIV:   if (rem_rsp.done) state_d = S_OUT;
			S_OUT:   if (m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lead_q     <= '1;
			trail_q    <= '0;
			held_q     <= '0;
			first_q    <= '0;
			last_q     <= '0;
			nonempty_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			lead_q     <= lead_d;
			trail_q    <= trail_d;
			held_q     <= held_d;
			first_q    <= first_d;
			last_q     <= last_d;
			nonempty_q <= nonempty_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q  <= s_tuser;
			nseq_q <= s_tdata[SEQ_W-1:0];
			plen_q <= s_tdata[SEQ_W+LEN_W-1:SEQ_W];
		end
		if (state_q == S_EXE) begin
			acc_q    <= acc_d;
			status_q <= status_d;
			seq_q    <= seq_d;
			par_q    <= par_d;
			pidx_q   <= '0;
		end else if (state_q == S_DIV && rem_rsp.done) begin
			pidx_q <= rem_rsp.rem;
		end
	end

	assign rem_req.start    = div_go;
	assign rem_req.dividend = sent_rd;
	assign rem_req.divisor  = span_q;

	twrq_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	twrq_ram #(.WIDTH(1), .DEPTH(WINDOW_SLOTS)) u_wait_ram (
		.clk(clk), .we(wait_we), .waddr(wait_wa), .wdata(wait_wd),
		.raddr(rd_addr), .rdata(wait_rd)
	);
	twrq_ram #(.WIDTH(CNT_W), .DEPTH(WINDOW_SLOTS)) u_req_ram (
		.clk(clk), .we(req_we), .waddr(req_wa), .wdata(req_wd),
		.raddr(rd_addr), .rdata(req_rd)
	);
	twrq_ram #(.WIDTH(CNT_W), .DEPTH(WINDOW_SLOTS)) u_sent_ram (
		.clk(clk), .we(sent_we), .waddr(sent_wa), .wdata(sent_wd),
		.raddr(rd_addr), .rdata(sent_rd)
	);
	twrq_ram #(.WIDTH(LEN_W), .DEPTH(WINDOW_SLOTS)) u_len_ram (
		.clk(clk), .we(len_we), .waddr(len_wa), .wdata(plen_q),
		.raddr(rd_addr), .rdata(len_rd)
	);
	twrq_ram #(.WIDTH(SLOT_W), .DEPTH(WINDOW_SLOTS)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(rd_addr), .rdata(prev_rd)
	);
	twrq_ram #(.WIDTH(SLOT_W), .DEPTH(WINDOW_SLOTS)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(rd_addr), .rdata(next_rd)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = {6'd0, held_q, fill[FILL_W-1:0], seq_q & gmask, pidx_q, par_q,
	                   seq_q, status_q, acc_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(lead_q + 1'b1 - trail_q) <= SEQ_W'(WINDOW_SLOTS))
		else $error("window holds more packets than slots");
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is pending");
	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_RD))
		else $error("accepted item did not start the slot read");
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		rem_rsp.busy |-> (state_q == S_DIV))
		else $error("remainder unit busy outside its wait state");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXE && acc_d && !nonempty_q) |=> (first_q == last_q))
		else $error("first push left head and tail apart");

endmodule

`default_nettype wire

### test/twrq_checker.sv
// ----------------------------------------------------------------------------
// twrq_checker
// Watches the command, result and register channels of the transmit window
// retransmit queue, predicts each result from its own window and queue model
// and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module twrq_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	input  wire logic         pready,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [47:0]  s_tdata,  // nak_sequence[31:0], packet_len[47:32]
	input  wire logic [2:0]   s_tuser,  // cmd[2:0]
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [119:0] m_tdata,  // accepted, status, seq_out, head_is_parity,
	                                    // parity_index, group_base, fill_count,
	                                    // byte_total
	output int                pending,
	output int                errors
);
	import twrq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [BYTES_W-1:0] byte_total;
		logic [FILL_W-1:0]  fill_count;
		logic [SEQ_W-1:0]   group_base;
		logic [CNT_W-1:0]   parity_index;
		logic               head_is_parity;
		logic [SEQ_W-1:0]   seq_out;
		logic [STAT_W-1:0]  status;
		logic               accepted;
	} outcome_t;

	outcome_t outcome_q[$];

	logic [GS_W-1:0]    group_shift;
	logic [CNT_W-1:0]   parity_span;
	logic [SEQ_W-1:0]   lead_seq, trail_seq;
	logic [BYTES_W-1:0] held_bytes;
	logic [SLOT_W-1:0]  head_slot, tail_slot;
	logic               queue_busy;
	logic               waiting[WINDOW_SLOTS];
	logic [CNT_W-1:0]   requested[WINDOW_SLOTS];
	logic [CNT_W-1:0]   sent[WINDOW_SLOTS];
	logic [LEN_W-1:0]   length[WINDOW_SLOTS];
	logic [SLOT_W-1:0]  prev_slot[WINDOW_SLOTS];
	logic [SLOT_W-1:0]  next_slot[WINDOW_SLOTS];

	function automatic logic [SEQ_W-1:0] held_count();
		return lead_seq + 32'd1 - trail_seq;
	endfunction

	function automatic void link_tail(logic [SLOT_W-1:0] s);
		if (!queue_busy) begin
			head_slot = s;
			tail_slot = s;
			queue_busy = 1'b1;
		end else begin
			next_slot[tail_slot] = s;
			prev_slot[s] = tail_slot;
			tail_slot = s;
		end
		waiting[s] = 1'b1;
	endfunction

	function automatic void unlink(logic [SLOT_W-1:0] s);
		if (s == head_slot && s == tail_slot) begin
			queue_busy = 1'b0;
		end else if (s == head_slot) begin
			head_slot = next_slot[s];
		end else if (s == tail_slot) begin
			tail_slot = prev_slot[s];
		end else begin
			next_slot[prev_slot[s]] = next_slot[s];
			prev_slot[next_slot[s]] = prev_slot[s];
		end
		waiting[s] = 1'b0;
	endfunction

	function automatic outcome_t window_step(logic [2:0] cmd, logic [31:0] nseq,
			logic [15:0] plen);
		outcome_t r;
		logic [31:0] mask, target, count;
		logic [SLOT_W-1:0] s;
		r = '0;
		mask = 32'hffff_ffff << group_shift;
		case (cmd)
			CMD_ADD: begin
				if (held_count() == WINDOW_SLOTS) begin
					s = trail_seq[SLOT_W-1:0];
					if (queue_busy && waiting[s])
						unlink(s);
					waiting[s] = 1'b0;
					held_bytes = held_bytes - BYTES_W'(length[s]);
					trail_seq = trail_seq + 32'd1;
				end
				lead_seq = lead_seq + 32'd1;
				s = lead_seq[SLOT_W-1:0];
				length[s] = plen;
				waiting[s] = 1'b0;
				requested[s] = '0;
				sent[s] = '0;
				held_bytes = held_bytes + BYTES_W'(plen);
				r.seq_out = lead_seq;
				r.group_base = lead_seq & mask;
			end
			CMD_SNAK, CMD_PNAK: begin
				target = (cmd == CMD_PNAK) ? (nseq & mask) : nseq;
				count = (cmd == CMD_PNAK) ? (nseq & ~mask) : 32'd0;
				if (held_count() == 0) begin
					r.status = ST_WIN_EMPTY;
				end else if (target - trail_seq > lead_seq - trail_seq) begin
					r.status = ST_NOT_IN;
				end else begin
					s = target[SLOT_W-1:0];
					if (waiting[s]) begin
						if (cmd == CMD_PNAK && 32'(requested[s]) < count)
							requested[s] = count[CNT_W-1:0];
						r.status = ST_DUP;
					end else begin
						if (cmd == CMD_PNAK)
							requested[s] = requested[s] + 1'b1;
						link_tail(s);
						r.accepted = 1'b1;
					end
				end
			end
			CMD_PEEK, CMD_REMOVE: begin
				if (!queue_busy) begin
					r.status = ST_Q_EMPTY;
				end else begin
					s = head_slot;
					r.seq_out = trail_seq + 32'(SLOT_W'(s - trail_seq[SLOT_W-1:0]));
					r.group_base = r.seq_out & mask;
					if (requested[s] != 0) begin
						r.head_is_parity = 1'b1;
						if (parity_span != 0)
							r.parity_index = sent[s] % parity_span;
					end
					if (cmd == CMD_REMOVE) begin
						if (requested[s] != 0) begin
							sent[s] = sent[s] + 1'b1;
							if (sent[s] == requested[s])
								unlink(s);
						end else begin
							unlink(s);
						end
					end
				end
			end
			default: ;
		endcase
		r.fill_count = FILL_W'(held_count());
		r.byte_total = held_bytes;
		return r;
	endfunction

	function automatic void report(string field, logic [31:0] want, logic [31:0] got);
		errors++;
		if (errors <= 10)
			$display("%0t mismatch %s: expected %0h actual %0h", $realtime, field, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want, got;
		if (!arst_n) begin
			group_shift = '0;
			parity_span = 8'd1;
			lead_seq = 32'hffff_ffff;
			trail_seq = '0;
			held_bytes = '0;
			head_slot = '0;
			tail_slot = '0;
			queue_busy = 1'b0;
			outcome_q.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_GROUP_SHIFT)
					group_shift = pwdata[GS_W-1:0];
				else
					parity_span = pwdata[CNT_W-1:0];
			end
			if (s_tvalid && s_tready)
				outcome_q.push_back(window_step(s_tuser, s_tdata[31:0], s_tdata[47:32]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[113:0];
				if (outcome_q.size() == 0) begin
					report("unexpected result", 0, 1);
				end else begin
					want = outcome_q.pop_front();
					if (got.accepted != want.accepted)
						report("accepted", want.accepted, got.accepted);
					if (got.status != want.status)
						report("status", want.status, got.status);
					if (got.seq_out != want.seq_out)
						report("seq_out", want.seq_out, got.seq_out);
					if (got.head_is_parity != want.head_is_parity)
						report("head_is_parity", want.head_is_parity, got.head_is_parity);
					if (got.parity_index != want.parity_index)
						report("parity_index", want.parity_index, got.parity_index);
					if (got.group_base != want.group_base)
						report("group_base", want.group_base, got.group_base);
					if (got.fill_count != want.fill_count)
						report("fill_count", want.fill_count, got.fill_count);
					if (got.byte_total != want.byte_total)
						report("byte_total", want.byte_total, got.byte_total);
				end
			end
			pending = outcome_q.size();
		end
	end

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives commands, register writes and result back-pressure into the transmit
// window retransmit queue: a directed opening, then random phases with
// different idle patterns and register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import twrq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk, arst_n;
	logic         psel, penable, pwrite, pready;
	logic [2:0]   paddr;
	logic [31:0]  pwdata, prdata;
	logic         s_tvalid, s_tready, m_tvalid, m_tready;
	logic [47:0]  s_tdata;  // nak_sequence[31:0], packet_len[47:32]
	logic [2:0]   s_tuser;  // cmd[2:0]
	logic [119:0] m_tdata;  // accepted[0], status[3:1], seq_out[35:4], ...
	int           pending, errors;

	int send_idle_pct, recv_stall_pct, holdoff;
	int add_pct;
	int added;
	logic [GS_W-1:0] shift_now;

	transmit_window_retransmit_queue_top i_dut (.*);
	twrq_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL transmit_window_retransmit_queue_top");
		$finish;
	end

	always @(posedge clk) begin
		if (holdoff > 0) begin
			holdoff <= holdoff - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic logic [31:0] trail_now();
		return (added > WINDOW_SLOTS) ? 32'(added - WINDOW_SLOTS) : 32'd0;
	endfunction

	function automatic logic [31:0] held_seq();
		int n;
		n = (added > WINDOW_SLOTS) ? WINDOW_SLOTS : added;
		if (n == 0)
			return $urandom;
		return trail_now() + $urandom_range(0, n - 1);
	endfunction

	task automatic issue(logic [2:0] cmd, logic [31:0] nseq, logic [15:0] plen);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {plen, nseq};
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_ADD)
			added++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(logic [GS_W-1:0] gs, logic [CNT_W-1:0] span);
		reg_write(3'd0, 32'(gs));
		reg_write(3'd4, 32'(span));
		shift_now = gs;
	endtask

	task automatic random_item();
		int r;
		logic [31:0] mask;
		r = $urandom_range(0, 99);
		mask = 32'hffff_ffff << shift_now;
		if (r < add_pct)
			issue(CMD_ADD, $urandom, 16'($urandom));
		else if (r < add_pct + (100 - add_pct) * 30 / 100)
			issue(CMD_SNAK, ($urandom_range(0, 9) < 8) ? held_seq() : $urandom,
				16'($urandom));
		else if (r < add_pct + (100 - add_pct) * 60 / 100)
			issue(CMD_PNAK, ($urandom_range(0, 9) < 8)
				? ((held_seq() & mask) | ($urandom & ~mask)) : $urandom, 16'($urandom));
		else if (r < add_pct + (100 - add_pct) * 72 / 100)
			issue(CMD_PEEK, $urandom, 16'($urandom));
		else if (r < add_pct + (100 - add_pct) * 96 / 100)
			issue(CMD_REMOVE, $urandom, 16'($urandom));
		else
			issue(3'($urandom_range(5, 7)), $urandom, 16'($urandom));
	endtask

	task automatic run_phase(int n, int idle, int stall, int adds);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		add_pct = adds;
		repeat (n) random_item();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_ADD;
		m_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff = 0;
		add_pct = 40;
		added = 0;
		shift_now = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(3'd2, 8'd3);
		issue(CMD_SNAK, 32'd0, 16'd0);
		issue(CMD_PNAK, 32'hffff_ffff, 16'hffff);
		issue(CMD_PEEK, 32'd0, 16'd0);
		issue(CMD_REMOVE, 32'd0, 16'd0);
		issue(3'd5, 32'hffff_ffff, 16'hffff);
		issue(3'd7, 32'h5555_aaaa, 16'h1234);
		issue(CMD_ADD, 32'd0, 16'd0);
		issue(CMD_ADD, 32'hffff_ffff, 16'hffff);
		repeat (6) issue(CMD_ADD, 32'd0, 16'h0100);
		issue(CMD_SNAK, 32'd8, 16'd0);
		issue(CMD_SNAK, 32'hffff_ffff, 16'd0);
		issue(CMD_SNAK, 32'd1, 16'd0);
		issue(CMD_SNAK, 32'd1, 16'd0);
		issue(CMD_PNAK, 32'd4 | 32'd1, 16'd0);
		issue(CMD_PNAK, 32'd4 | 32'd3, 16'd0);
		issue(CMD_PEEK, 32'd0, 16'd0);
		issue(CMD_REMOVE, 32'd0, 16'd0);
		issue(CMD_PEEK, 32'd0, 16'd0);
		repeat (4) issue(CMD_REMOVE, 32'd0, 16'd0);
		drain();

		configure(3'd7, 8'd255);
		holdoff = 300;
		run_phase(130, 0, 0, 40);
		configure(3'd0, 8'd1);
		run_phase(130, 70, 0, 40);
		configure(3'd3, 8'd5);
		run_phase(130, 0, 70, 40);
		configure(3'd1, 8'd2);
		run_phase(130, 28, 28, 40);
		configure(3'd4, 8'd7);
		run_phase(150, 10, 10, 80);

		if (errors == 0)
			$display("PASS transmit_window_retransmit_queue_top");
		else
			$display("FAIL transmit_window_retransmit_queue_top");
		$finish;
	end

endmodule

`default_nettype wire
